@@ sv/pss_pkg.sv @@
// shared types, constants and helpers of the step sequencer
package pss_pkg;

    localparam int DEF_LANES = 4;
    localparam int DEF_STEPS = 32;

    localparam int PHASE_W = 24;
    localparam int LEVEL_W = 13;
    localparam int ADV_W   = 25;
    localparam int RATE_W  = 10;
    localparam int LEN_W   = 6;
    localparam int LFSR_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    localparam logic [LEVEL_W-1:0] LEVEL_ONE   = 13'd4096;
    localparam logic [LFSR_W-1:0]  LFSR_SEED   = 16'd44257;
    localparam logic [LFSR_W-1:0]  LFSR_TAPS   = 16'hB400;
    localparam logic [LEVEL_W-1:0] GATE_THRESH = 13'd205;

    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_WRITE   = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    localparam logic [1:0] KIND_PITCH  = 2'd1;
    localparam logic [1:0] KIND_GATE   = 2'd2;
    localparam logic [1:0] KIND_CHANCE = 2'd3;

    localparam logic [1:0] DIR_FWD  = 2'd0;
    localparam logic [1:0] DIR_REV  = 2'd1;
    localparam logic [1:0] DIR_PING = 2'd2;
    localparam logic [1:0] DIR_RAND = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KINDS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIRS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LENS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RATES  = 3'd4;

    typedef struct packed {
        logic [1:0]         action;
        logic [ADV_W-1:0]   tick_advance;
        logic [1:0]         lane_select;
        logic [4:0]         step_select;
        logic [LEVEL_W-1:0] step_level;
    } in_item_t;

    typedef struct packed {
        logic signed [7:0]  pitch_offset;
        logic [LEVEL_W-1:0] gate_level;
        logic [LEVEL_W-1:0] chance_level;
        logic               gate_open;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic clear_acc;  // start of a tick: reset accumulators
        logic restart;    // put lanes before step 0
        logic write_step; // store step value
        logic advance;    // phase add and move for current lane
        logic lookup;     // issue step read for current lane
        logic combine;    // fold read value into sums
    } dp_cmd_t;

    // round((3v - 6144)/256), ties to even
    function automatic logic signed [7:0] pitch_of(input logic [LEVEL_W-1:0] v);
        logic [15:0] u;
        logic [7:0]  rem;
        logic signed [7:0] q;
        begin
            u   = 16'(3 * 32'(v)) + 16'd2048;
            rem = u[7:0];
            q   = 8'(signed'({2'b00, u[15:8]}) - 10'sd32);
            if (rem > 8'd128 || (rem == 8'd128 && q[0]))
                q = q + 8'sd1;
            pitch_of = q;
        end
    endfunction

endpackage

@@ sv/pss_if.sv @@
// valid/ready channel carrying one item per beat
interface pss_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/polyrhythmic_step_sequencer.sv @@
// top level of the polyrhythmic step sequencer
// A tick beat walks the lanes one at a time through phase add and move,
// a registered step memory read, and a multiply or pitch add into the
// running result; the result then sits in an output register until taken.
// Write and restart beats are done in the idle state and end there.
// Step values that were never written read as undefined.
module polyrhythmic_step_sequencer import pss_pkg::*; #(
    parameter int LANES = DEF_LANES,
    parameter int STEPS = DEF_STEPS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    pss_if.sink                   in_ch,
    pss_if.source                 out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    logic [LANES-1:0]        en_reg;
    logic [2*LANES-1:0]      kind_reg, dir_reg;
    logic [LEN_W*LANES-1:0]  len_reg;
    logic [RATE_W*LANES-1:0] rate_reg;

    // fields past the fourth lane read as zero
    function automatic logic [CFG_DATA_W-1:0] fit(input logic [CFG_DATA_W-1:0] v,
                                                  input int w);
        fit = v & ((CFG_DATA_W'(1) << w) - 1'b1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg   <= '0;
            kind_reg <= (2*LANES)'(fit(40'd170, 8));
            dir_reg  <= '0;
            len_reg  <= (LEN_W*LANES)'(fit(40'd8421504, 24));
            rate_reg <= (RATE_W*LANES)'(fit(40'd17180131344, 40));
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ENABLE: en_reg   <= LANES'(fit(cfg_data, 4));
                REG_KINDS:  kind_reg <= (2*LANES)'(fit(cfg_data, 8));
                REG_DIRS:   dir_reg  <= (2*LANES)'(fit(cfg_data, 8));
                REG_LENS:   len_reg  <= (LEN_W*LANES)'(fit(cfg_data, 24));
                REG_RATES:  rate_reg <= (RATE_W*LANES)'(fit(cfg_data, 40));
                default: ;
            endcase
        end
    end

    dp_cmd_t                    cmd;
    logic [$clog2(LANES+1)-1:0] lane;
    logic                       out_load;
    out_item_t                  result;
    logic                       out_valid_reg;
    out_item_t                  out_data_reg;

    pss_ctrl #(.LANES(LANES)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_action (in_ch.data.action),
        .in_ready  (in_ch.ready),
        .out_busy  (out_valid_reg && !out_ch.ready),
        .out_load  (out_load),
        .lane      (lane),
        .cmd       (cmd)
    );

    pss_dp #(.LANES(LANES), .STEPS(STEPS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .lane      (lane),
        .item      (in_ch.data),
        .en_bits   (en_reg),
        .kind_bits (kind_reg),
        .dir_bits  (dir_reg),
        .len_bits  (len_reg),
        .rate_bits (rate_reg),
        .result    (result)
    );

    // result beat held until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_data_reg <= result;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;
endmodule

@@ sv/pss_ctrl.sv @@
// controller: sequences one item over the lanes
module pss_ctrl import pss_pkg::*; #(
    parameter int LANES = DEF_LANES
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [1:0]                in_action,
    output logic                      in_ready,
    input  logic                      out_busy,
    output logic                      out_load,
    output logic [$clog2(LANES+1)-1:0] lane,
    output dp_cmd_t                   cmd
);
    localparam int LW = $clog2(LANES+1);
    localparam logic [2:0] S_IDLE = 3'd0, S_ADV = 3'd1, S_READ = 3'd2,
                           S_COMB = 3'd3, S_DONE = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [LW-1:0] lane_reg, lane_next;

    assign lane     = lane_reg;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        lane_next  = lane_reg;
        cmd        = '0;
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_action)
                        ACT_TICK:
                        begin
                            cmd.clear_acc = 1'b1;
                            lane_next  = '0;
                            state_next = S_ADV;
                        end
                        ACT_WRITE:   cmd.write_step = 1'b1;
                        ACT_RESTART: cmd.restart = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_ADV:
            begin
                cmd.advance = 1'b1;
                state_next  = S_READ;
            end
            S_READ:
            begin
                cmd.lookup = 1'b1;
                state_next = S_COMB;
            end
            S_COMB:
            begin
                cmd.combine = 1'b1;
                lane_next   = lane_reg + 1'b1;
                state_next  = (lane_reg == LW'(LANES - 1)) ? S_DONE : S_ADV;
            end
            S_DONE:
            begin
                if (!out_busy)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            lane_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lane_reg  <= lane_next;
        end
    end
endmodule

@@ sv/pss_dp.sv @@
// datapath: lane state, step memory, lfsr and result accumulators
module pss_dp import pss_pkg::*; #(
    parameter int LANES = DEF_LANES,
    parameter int STEPS = DEF_STEPS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  dp_cmd_t                    cmd,
    input  logic [$clog2(LANES+1)-1:0] lane,
    input  in_item_t                   item,
    input  logic [LANES-1:0]           en_bits,
    input  logic [2*LANES-1:0]         kind_bits,
    input  logic [2*LANES-1:0]         dir_bits,
    input  logic [LEN_W*LANES-1:0]     len_bits,
    input  logic [RATE_W*LANES-1:0]    rate_bits,
    output out_item_t                  result
);
    localparam int SW = $clog2(STEPS);
    localparam int LI = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int AW = LI + SW;
    localparam int PW = $clog2(STEPS + 1);
    localparam int SUM_W = ADV_W + RATE_W - 4;

    logic [LEVEL_W-1:0] mem [LANES*STEPS];
    logic [LEVEL_W-1:0] rd_data_reg;
    logic [ADV_W-1:0]   adv_reg;

    logic [PHASE_W-1:0] phase_reg [LANES];
    logic [SW-1:0]      pos_reg   [LANES];
    logic [LANES-1:0]   started_reg, up_reg;
    logic [LFSR_W-1:0]  lfsr_reg;

    logic signed [9:0]  pitch_reg;
    logic [LEVEL_W-1:0] gate_reg, chance_reg;

    logic [LI-1:0]      li;
    logic               act;
    logic [1:0]         kind, dir;
    logic [LEN_W-1:0]   len_raw;
    logic [PW-1:0]      len;
    logic [RATE_W-1:0]  rate_raw, rate;
    logic [34:0]        prod;
    logic [SUM_W-1:0]   sum;
    logic signed [PW+1:0] p, n;
    logic [PW+LEN_W-1:0] fwd_rem;
    logic               up_next;
    logic [LFSR_W-1:0]  lfsr_next;
    logic [LFSR_W+PW-1:0] rprod;
    logic [PW-1:0]      rd_idx;
    logic [SW-1:0]      rd_pos;
    logic [LEVEL_W-1:0] lvl;
    logic [25:0]        gmul, cmul;

    assign li       = LI'(lane);
    assign act      = en_bits[li];
    assign kind     = kind_bits[2*li +: 2];
    assign dir      = dir_bits[2*li +: 2];
    assign len_raw  = len_bits[LEN_W*li +: LEN_W];
    assign rate_raw = rate_bits[RATE_W*li +: RATE_W];

    always_comb
    begin
        if (len_raw == '0)
            len = PW'(1);
        else if (32'(len_raw) > STEPS)
            len = PW'(STEPS);
        else
            len = PW'(len_raw);
        if (rate_raw == '0)
            rate = 10'd1;
        else if (rate_raw > 10'd512)
            rate = 10'd512;
        else
            rate = rate_raw;
    end

    assign prod = 35'(adv_reg) * 35'(rate);
    assign sum  = SUM_W'(phase_reg[li]) + SUM_W'(prod >> 4);

    assign lfsr_next = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_TAPS) : (lfsr_reg >> 1);
    assign rprod     = (LFSR_W+PW)'(lfsr_next) * (LFSR_W+PW)'(len);

    always_comb
    begin
        p       = started_reg[li] ? (PW+2)'(pos_reg[li]) : -(PW+2)'(1);
        up_next = up_reg[li];
        n       = '0;
        fwd_rem = '0;
        case (dir)
            DIR_REV:
            begin
                n = p - 1;
                if (n < 0)
                    n = (PW+2)'(len) - 1;
            end
            DIR_PING:
            begin
                if (up_reg[li])
                begin
                    n = p + 1;
                    if (n >= (PW+2)'(len))
                    begin
                        n = (PW+2)'(len) - 2;
                        up_next = 1'b0;
                    end
                end
                else
                begin
                    n = p - 1;
                    if (n < 0)
                    begin
                        n = 1;
                        up_next = 1'b1;
                    end
                end
                if (n > (PW+2)'(len) - 1)
                    n = (PW+2)'(len) - 1;
                if (n < 0)
                    n = '0;
            end
            DIR_RAND: n = (PW+2)'(rprod >> LFSR_W);
            default:
            begin
                // remainder by compare and subtract, position may exceed the length
                fwd_rem = (PW+LEN_W)'(p + 1);
                for (int k = LEN_W-1; k >= 0; k--)
                begin
                    if (fwd_rem >= ((PW+LEN_W)'(len) << k))
                        fwd_rem = fwd_rem - ((PW+LEN_W)'(len) << k);
                end
                n = (PW+2)'(fwd_rem);
            end
        endcase
    end

    // read index clamped to the current length
    always_comb
    begin
        rd_idx = started_reg[li] ? PW'(pos_reg[li]) : '0;
        if (rd_idx > len - 1'b1)
            rd_idx = len - 1'b1;
        rd_pos = SW'(rd_idx);
    end

    assign lvl = (item.step_level > LEVEL_ONE) ? LEVEL_ONE : item.step_level;

    always_ff @(posedge clk)
    begin
        if (cmd.write_step && 32'(item.lane_select) < LANES
            && 32'(item.step_select) < STEPS)
            mem[AW'(item.lane_select) * AW'(STEPS) + AW'(item.step_select)] <= lvl;
        if (cmd.lookup)
            rd_data_reg <= mem[AW'(li) * AW'(STEPS) + AW'(rd_pos)];
        // advance held for the whole tick
        if (cmd.clear_acc)
            adv_reg <= item.tick_advance;
    end

    assign gmul = 26'(gate_reg) * 26'(rd_data_reg) + 26'd2048;
    assign cmul = 26'(chance_reg) * 26'(rd_data_reg) + 26'd2048;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                phase_reg[i] <= '0;
                pos_reg[i]   <= '0;
            end
            started_reg <= '0;
            up_reg      <= '1;
            lfsr_reg    <= LFSR_SEED;
            pitch_reg   <= '0;
            gate_reg    <= LEVEL_ONE;
            chance_reg  <= LEVEL_ONE;
        end
        else
        begin
            if (cmd.restart)
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    phase_reg[i] <= '0;
                    pos_reg[i]   <= '0;
                end
                started_reg <= '0;
                up_reg      <= '1;
            end
            if (cmd.clear_acc)
            begin
                pitch_reg  <= '0;
                gate_reg   <= LEVEL_ONE;
                chance_reg <= LEVEL_ONE;
            end
            if (cmd.advance && act)
            begin
                phase_reg[li] <= sum[PHASE_W-1:0];
                if (|sum[SUM_W-1:PHASE_W])
                begin
                    pos_reg[li]     <= SW'(n);
                    started_reg[li] <= 1'b1;
                    up_reg[li]      <= up_next;
                    if (dir == DIR_RAND)
                        lfsr_reg <= lfsr_next;
                end
            end
            if (cmd.combine && act)
            begin
                case (kind)
                    KIND_PITCH:  pitch_reg  <= pitch_reg + 10'(pitch_of(rd_data_reg));
                    KIND_GATE:   gate_reg   <= LEVEL_W'(gmul >> 12);
                    KIND_CHANCE: chance_reg <= LEVEL_W'(cmul >> 12);
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        if (pitch_reg > 10'sd127)
            result.pitch_offset = 8'sd127;
        else if (pitch_reg < -10'sd128)
            result.pitch_offset = -8'sd128;
        else
            result.pitch_offset = 8'(pitch_reg);
        result.gate_level   = gate_reg;
        result.chance_level = chance_reg;
        result.gate_open    = gate_reg > GATE_THRESH;
    end
endmodule
